// ===== rtl/itpt_pkg.sv =====
// ============================================================================
// itpt_pkg: shared definitions for the integer to padded text formatter
// Field widths, flag bit positions, character codes, the commands passed
// between the sequencer and the character emitter, and the digit lookup.
// ============================================================================
package itpt_pkg;

    localparam int MAX_FIELD  = 60;
    localparam int VALUE_BITS = 32;

    // Port widths fixed by the item format.
    localparam int VALUE_PORT_W = 32;
    localparam int BASE_W       = 6;
    localparam int WIDTH_W      = 6;
    localparam int PREC_W       = 7;
    localparam int FLAGS_W      = 7;
    localparam int CHAR_W       = 7;

    localparam int BASE_MIN   = 2;
    localparam int BASE_MAX   = 36;
    localparam int DEC_DIGITS = 10;

    // Divider: DIV_STEP_BITS quotient bits are resolved per cycle.
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_CYCLES    = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DIV_W         = DIV_CYCLES * DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    localparam int ADDR_W  = $clog2(VALUE_BITS);
    localparam int DCNT_W  = $clog2(VALUE_BITS + 1);
    localparam int LEN_MAX = (MAX_FIELD > VALUE_BITS) ? MAX_FIELD : VALUE_BITS;
    localparam int LEN_W   = $clog2(LEN_MAX + 1);

    // Flag bit positions.
    localparam int BIT_ZPAD  = 0;
    localparam int BIT_SGN   = 1;
    localparam int BIT_PLUS  = 2;
    localparam int BIT_BLANK = 3;
    localparam int BIT_LJUST = 4;
    localparam int BIT_ALT   = 5;
    localparam int BIT_CAPS  = 6;

    typedef logic [CHAR_W-1:0]     char_t;
    typedef logic [BASE_W-1:0]     digit_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [DIV_W-1:0]      divw_t;
    typedef logic [DIV_CNT_W-1:0]  divcnt_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [DCNT_W-1:0]     dcnt_t;
    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [LEN_W:0]        lenx_t;

    localparam char_t CH_NUL     = 7'h00;
    localparam char_t CH_SPACE   = 7'h20;
    localparam char_t CH_PLUS    = 7'h2B;
    localparam char_t CH_MINUS   = 7'h2D;
    localparam char_t CH_ZERO    = 7'h30;
    localparam char_t CH_A_UPPER = 7'h41;
    localparam char_t CH_X_UPPER = 7'h58;
    localparam char_t CH_A_LOWER = 7'h61;
    localparam char_t CH_X_LOWER = 7'h78;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        digit_t data;
    } digit_wr_t;

    typedef struct packed {
        logic        start;
        logic        err;
        len_t        lead;
        logic        sign_en;
        char_t       sign_char;
        logic [1:0]  pfx_len;
        len_t        zfill;
        len_t        pzero;
        dcnt_t       digits;
        len_t        trail;
        logic        upper;
    } emit_cmd_t;

    function automatic char_t digit_char(input digit_t d, input logic upper);
        char_t c;
        if (d < digit_t'(DEC_DIGITS))
            c = CH_ZERO + char_t'(d);
        else if (upper)
            c = CH_A_UPPER + char_t'(d - digit_t'(DEC_DIGITS));
        else
            c = CH_A_LOWER + char_t'(d - digit_t'(DEC_DIGITS));
        return c;
    endfunction

endpackage

// ===== rtl/itpt_divider.sv =====
// ============================================================================
// itpt_divider: iterative divide of the value by the base
// Restoring division that settles four quotient bits per cycle and returns
// quotient and remainder together with a one-cycle done pulse.
// ============================================================================
module itpt_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  itpt_pkg::value_t  dividend,
    input  itpt_pkg::digit_t  divisor,
    output logic              done,
    output itpt_pkg::value_t  quotient,
    output itpt_pkg::digit_t  remainder
);

    itpt_pkg::divw_t   work_reg, work_next;
    itpt_pkg::digit_t  rem_reg, rem_next;
    itpt_pkg::digit_t  divisor_reg, divisor_next;
    itpt_pkg::divcnt_t cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    itpt_pkg::digit_t                      step_rem;
    logic [itpt_pkg::DIV_STEP_BITS-1:0]    step_q;

    // The dividend bits go out at the top of the work register while the
    // quotient bits come in at the bottom.
    always_comb
    begin : chunk
        logic [itpt_pkg::BASE_W:0] trial;
        logic [itpt_pkg::BASE_W:0] dvs;
        step_rem = rem_reg;
        step_q   = '0;
        dvs      = {1'b0, divisor_reg};
        for (int i = 0; i < itpt_pkg::DIV_STEP_BITS; i++)
        begin
            trial = {step_rem, work_reg[itpt_pkg::DIV_W-1-i]};
            if (trial >= dvs)
            begin
                step_rem = itpt_pkg::digit_t'(trial - dvs);
                step_q[itpt_pkg::DIV_STEP_BITS-1-i] = 1'b1;
            end
            else
            begin
                step_rem = trial[itpt_pkg::BASE_W-1:0];
            end
        end
    end

    always_comb
    begin
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start)
        begin
            work_next    = itpt_pkg::divw_t'(dividend);
            rem_next     = '0;
            divisor_next = divisor;
            cnt_next     = '0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[itpt_pkg::DIV_W-itpt_pkg::DIV_STEP_BITS-1:0], step_q};
            rem_next  = step_rem;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == itpt_pkg::divcnt_t'(itpt_pkg::DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg    <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            work_reg    <= work_next;
            rem_reg     <= rem_next;
            divisor_reg <= divisor_next;
            cnt_reg     <= cnt_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg[itpt_pkg::VALUE_BITS-1:0];
    assign remainder = rem_reg;

endmodule

// ===== rtl/itpt_emitter.sv =====
// ============================================================================
// itpt_emitter: character emitter with digit store
// Walks the segments of the field (leading spaces, sign, prefix, zero
// filler, precision zeros, digits, trailing spaces) one character per cycle
// into a registered output slot while it is free; an error command gives a lone NUL.
// ============================================================================
module itpt_emitter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  itpt_pkg::emit_cmd_t  cmd,
    input  itpt_pkg::digit_wr_t  dwr,
    output logic                 busy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output itpt_pkg::char_t      character,
    output logic                 last,
    output logic                 bad_base
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_PFX,
        PH_ZFILL,
        PH_PZERO,
        PH_DIG,
        PH_TRAIL,
        PH_IDLE
    } phase_t;

    localparam int NumPh = 8;

    // Lowest non-empty segment at or after lo; idle when there is none.
    function automatic phase_t first_from(input logic [NumPh-1:0] m, input logic [2:0] lo);
        phase_t p;
        p = PH_IDLE;
        for (int j = NumPh - 2; j >= 0; j--)
        begin
            if (m[j] && (j >= int'(lo)))
                p = phase_t'(3'(j));
        end
        return p;
    endfunction

    phase_t             phase_reg, phase_next;
    itpt_pkg::len_t     cnt_reg, cnt_next;
    itpt_pkg::len_t     len_reg [NumPh];
    itpt_pkg::len_t     len_next [NumPh];
    itpt_pkg::len_t     cmd_len [NumPh];
    itpt_pkg::char_t    sign_char_reg, sign_char_next;
    logic               pfx2_reg, pfx2_next;
    logic               upper_reg, upper_next;
    logic               err_reg, err_next;
    itpt_pkg::addr_t    dptr_reg, dptr_next;
    logic               out_valid_reg, out_valid_next;
    itpt_pkg::char_t    out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;
    logic               out_bad_reg, out_bad_next;

    itpt_pkg::digit_t   mem [itpt_pkg::VALUE_BITS];
    itpt_pkg::digit_t   rd_data_reg;

    logic [NumPh-1:0]   len_mask;
    logic [NumPh-1:0]   cmd_mask;
    phase_t             after;
    phase_t             first;
    itpt_pkg::char_t    cur_char;
    logic               slot_free;

    always_comb
    begin
        cmd_len[0] = cmd.lead;
        cmd_len[1] = itpt_pkg::len_t'(cmd.sign_en);
        cmd_len[2] = itpt_pkg::len_t'(cmd.pfx_len);
        cmd_len[3] = cmd.zfill;
        cmd_len[4] = cmd.pzero;
        cmd_len[5] = itpt_pkg::len_t'(cmd.digits);
        cmd_len[6] = cmd.trail;
        cmd_len[7] = '0;
        for (int j = 0; j < NumPh; j++)
        begin
            cmd_mask[j] = (cmd_len[j] != '0);
            len_mask[j] = (len_reg[j] != '0);
        end
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign after     = first_from(len_mask, 3'(phase_reg) + 3'd1);
    assign first     = first_from(cmd_mask, 3'd0);

    always_comb
    begin
        unique case (phase_reg) inside
            PH_LEAD, PH_TRAIL:  cur_char = itpt_pkg::CH_SPACE;
            PH_SIGN:            cur_char = sign_char_reg;
            PH_PFX:
            begin
                // With a two-character prefix the second one is the x.
                if (pfx2_reg && (cnt_reg == itpt_pkg::len_t'(1)))
                    cur_char = upper_reg ? itpt_pkg::CH_X_UPPER : itpt_pkg::CH_X_LOWER;
                else
                    cur_char = itpt_pkg::CH_ZERO;
            end
            PH_ZFILL, PH_PZERO: cur_char = itpt_pkg::CH_ZERO;
            PH_DIG:             cur_char = itpt_pkg::digit_char(rd_data_reg, upper_reg);
            default:            cur_char = itpt_pkg::CH_NUL;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        sign_char_next = sign_char_reg;
        pfx2_next      = pfx2_reg;
        upper_next     = upper_reg;
        err_next       = err_reg;
        dptr_next      = dptr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;

        if (cmd.start)
        begin
            if (cmd.err)
            begin
                err_next = 1'b1;
            end
            else
            begin
                len_next       = cmd_len;
                phase_next     = first;
                cnt_next       = cmd_len[3'(first)];
                sign_char_next = cmd.sign_char;
                pfx2_next      = (cmd.pfx_len == 2'd2);
                upper_next     = cmd.upper;
                dptr_next      = itpt_pkg::addr_t'(cmd.digits - 1'b1);
            end
        end
        else if (slot_free && err_reg)
        begin
            out_valid_next = 1'b1;
            out_char_next  = itpt_pkg::CH_NUL;
            out_last_next  = 1'b1;
            out_bad_next   = 1'b1;
            err_next       = 1'b0;
        end
        else if (slot_free && (phase_reg != PH_IDLE))
        begin
            out_valid_next = 1'b1;
            out_char_next  = cur_char;
            out_last_next  = (cnt_reg == itpt_pkg::len_t'(1)) && (after == PH_IDLE);
            out_bad_next   = 1'b0;
            if (phase_reg == PH_DIG)
                dptr_next = dptr_reg - 1'b1;
            if (cnt_reg == itpt_pkg::len_t'(1))
            begin
                phase_next = after;
                cnt_next   = len_reg[3'(after)];
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            for (int j = 0; j < NumPh; j++)
                len_reg[j] <= '0;
            sign_char_reg <= itpt_pkg::CH_NUL;
            pfx2_reg      <= 1'b0;
            upper_reg     <= 1'b0;
            err_reg       <= 1'b0;
            dptr_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= itpt_pkg::CH_NUL;
            out_last_reg  <= 1'b0;
            out_bad_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            sign_char_reg <= sign_char_next;
            pfx2_reg      <= pfx2_next;
            upper_reg     <= upper_next;
            err_reg       <= err_next;
            dptr_reg      <= dptr_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
            out_bad_reg   <= out_bad_next;
        end
    end

    // The read address follows the digit pointer's next value, so the
    // registered read data always holds the digit under the pointer.
    always_ff @(posedge clk)
    begin
        if (dwr.en)
            mem[dwr.addr] <= dwr.data;
        rd_data_reg <= mem[dptr_next];
    end

    assign busy      = (phase_reg != PH_IDLE) || err_reg;
    assign out_valid = out_valid_reg;
    assign character = out_char_reg;
    assign last      = out_last_reg;
    assign bad_base  = out_bad_reg;

endmodule

// ===== rtl/integer_to_padded_text.sv =====
// ============================================================================
// integer_to_padded_text: printf-style integer formatter
// Converts one value to its digits in a base from 2 to 36 and emits the
// padded field as a run of characters with the final one marked.
// ============================================================================
// One item is taken at a time. After acceptance the value is split into
// digits by a shared iterative divider that settles four quotient bits per
// cycle; each time a division finishes its remainder is stored as the next
// digit and, while the quotient is not zero, the divider restarts on it.
// The S_SETUP state then sizes the padding, and the field leaves at one
// character per cycle while the output is taken. A bad base sets an error
// flag that loads its single result into the output register once the slot
// is free, and the input is ready again in the cycle after that. After a
// proper field the input is ready again in the cycle after the last
// character has entered the output register.
module integer_to_padded_text (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [itpt_pkg::VALUE_PORT_W-1:0]   value,
    input  logic [itpt_pkg::BASE_W-1:0]         base,
    input  logic [itpt_pkg::WIDTH_W-1:0]        width,
    input  logic signed [itpt_pkg::PREC_W-1:0]  precision,
    input  logic [itpt_pkg::FLAGS_W-1:0]        flags,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [itpt_pkg::CHAR_W-1:0]         character,
    output logic                                last,
    output logic                                bad_base
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SETUP,
        S_EMIT
    } state_t;

    state_t                               state_reg, state_next;
    itpt_pkg::dcnt_t                      dcnt_reg, dcnt_next;
    itpt_pkg::digit_t                     base_reg, base_next;
    logic [itpt_pkg::WIDTH_W-1:0]         width_reg, width_next;
    logic signed [itpt_pkg::PREC_W-1:0]   prec_reg, prec_next;
    logic                                 sign_en_reg, sign_en_next;
    itpt_pkg::char_t                      sign_char_reg, sign_char_next;
    logic [1:0]                           pfx_reg, pfx_next;
    logic                                 zero_reg, zero_next;
    logic                                 left_reg, left_next;
    logic                                 upper_reg, upper_next;

    itpt_pkg::value_t     in_val;
    itpt_pkg::value_t     in_mag;
    logic                 in_neg;
    logic                 in_bad;
    logic                 in_sign_en;
    itpt_pkg::char_t      in_sign_char;
    logic [1:0]           in_pfx;

    logic                 div_start;
    itpt_pkg::value_t     div_dividend;
    itpt_pkg::digit_t     div_divisor;
    logic                 div_done;
    itpt_pkg::value_t     div_quot;
    itpt_pkg::digit_t     div_rem;

    itpt_pkg::len_t       w_sat;
    itpt_pkg::len_t       p_eff;
    itpt_pkg::len_t       pe;
    itpt_pkg::lenx_t      used;
    itpt_pkg::len_t       pad;

    itpt_pkg::emit_cmd_t  cmd;
    itpt_pkg::digit_wr_t  dwr;
    logic                 emit_busy;

    // Decode of the incoming item.
    always_comb
    begin
        in_val = value[itpt_pkg::VALUE_BITS-1:0];
        in_neg = flags[itpt_pkg::BIT_SGN] && in_val[itpt_pkg::VALUE_BITS-1];
        in_mag = in_neg ? (~in_val + 1'b1) : in_val;
        in_bad = (int'(base) < itpt_pkg::BASE_MIN) || (int'(base) > itpt_pkg::BASE_MAX);

        in_sign_en   = 1'b0;
        in_sign_char = itpt_pkg::CH_NUL;
        if (in_neg)
        begin
            in_sign_en   = 1'b1;
            in_sign_char = itpt_pkg::CH_MINUS;
        end
        else if (flags[itpt_pkg::BIT_SGN] && flags[itpt_pkg::BIT_PLUS])
        begin
            in_sign_en   = 1'b1;
            in_sign_char = itpt_pkg::CH_PLUS;
        end
        else if (flags[itpt_pkg::BIT_SGN] && flags[itpt_pkg::BIT_BLANK])
        begin
            in_sign_en   = 1'b1;
            in_sign_char = itpt_pkg::CH_SPACE;
        end

        in_pfx = 2'd0;
        if (flags[itpt_pkg::BIT_ALT] && (int'(base) == 16))
            in_pfx = 2'd2;
        else if (flags[itpt_pkg::BIT_ALT] && (int'(base) == 8))
            in_pfx = 2'd1;
    end

    // Field sizing from the digit count once conversion has finished.
    always_comb
    begin
        w_sat = (int'(width_reg) > itpt_pkg::MAX_FIELD) ?
                itpt_pkg::len_t'(itpt_pkg::MAX_FIELD) : itpt_pkg::len_t'(width_reg);
        if (prec_reg[itpt_pkg::PREC_W-1])
            p_eff = '0;
        else if (int'(prec_reg) > itpt_pkg::MAX_FIELD)
            p_eff = itpt_pkg::len_t'(itpt_pkg::MAX_FIELD);
        else
            p_eff = itpt_pkg::len_t'(prec_reg);
        pe   = (p_eff > itpt_pkg::len_t'(dcnt_reg)) ? p_eff : itpt_pkg::len_t'(dcnt_reg);
        used = itpt_pkg::lenx_t'(pe) + itpt_pkg::lenx_t'(sign_en_reg) +
               itpt_pkg::lenx_t'(pfx_reg);
        pad  = (itpt_pkg::lenx_t'(w_sat) > used) ?
               itpt_pkg::len_t'(itpt_pkg::lenx_t'(w_sat) - used) : '0;
    end

    always_comb
    begin
        cmd.start     = ((state_reg == S_IDLE) && in_valid && in_bad) ||
                        (state_reg == S_SETUP);
        cmd.err       = (state_reg == S_IDLE);
        cmd.lead      = (!zero_reg && !left_reg) ? pad : '0;
        cmd.sign_en   = sign_en_reg;
        cmd.sign_char = sign_char_reg;
        cmd.pfx_len   = pfx_reg;
        cmd.zfill     = zero_reg ? pad : '0;
        cmd.pzero     = pe - itpt_pkg::len_t'(dcnt_reg);
        cmd.digits    = dcnt_reg;
        cmd.trail     = left_reg ? pad : '0;
        cmd.upper     = upper_reg;
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = in_mag;
        div_divisor  = base_reg;
        if (state_reg == S_IDLE)
        begin
            div_divisor = base;
            div_start   = in_valid && !in_bad;
        end
        else if ((state_reg == S_CONV) && div_done && (div_quot != '0))
        begin
            div_dividend = div_quot;
            div_start    = 1'b1;
        end

        dwr.en   = (state_reg == S_CONV) && div_done;
        dwr.addr = itpt_pkg::addr_t'(dcnt_reg);
        dwr.data = div_rem;
    end

    always_comb
    begin
        state_next     = state_reg;
        dcnt_next      = dcnt_reg;
        base_next      = base_reg;
        width_next     = width_reg;
        prec_next      = prec_reg;
        sign_en_next   = sign_en_reg;
        sign_char_next = sign_char_reg;
        pfx_next       = pfx_reg;
        zero_next      = zero_reg;
        left_next      = left_reg;
        upper_next     = upper_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    base_next      = base;
                    width_next     = width;
                    prec_next      = precision;
                    sign_en_next   = in_sign_en;
                    sign_char_next = in_sign_char;
                    pfx_next       = in_pfx;
                    // Left justification cancels zero padding.
                    zero_next      = flags[itpt_pkg::BIT_ZPAD] && !flags[itpt_pkg::BIT_LJUST];
                    left_next      = flags[itpt_pkg::BIT_LJUST];
                    upper_next     = flags[itpt_pkg::BIT_CAPS];
                    dcnt_next      = '0;
                    state_next     = in_bad ? S_EMIT : S_CONV;
                end
            end
            S_CONV:
            begin
                if (div_done)
                begin
                    dcnt_next = dcnt_reg + 1'b1;
                    if (div_quot == '0)
                        state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!emit_busy)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dcnt_reg      <= '0;
            base_reg      <= '0;
            width_reg     <= '0;
            prec_reg      <= '0;
            sign_en_reg   <= 1'b0;
            sign_char_reg <= itpt_pkg::CH_NUL;
            pfx_reg       <= 2'd0;
            zero_reg      <= 1'b0;
            left_reg      <= 1'b0;
            upper_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dcnt_reg      <= dcnt_next;
            base_reg      <= base_next;
            width_reg     <= width_next;
            prec_reg      <= prec_next;
            sign_en_reg   <= sign_en_next;
            sign_char_reg <= sign_char_next;
            pfx_reg       <= pfx_next;
            zero_reg      <= zero_next;
            left_reg      <= left_next;
            upper_reg     <= upper_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    itpt_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    itpt_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .dwr       (dwr),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last),
        .bad_base  (bad_base)
    );

endmodule

// ===== rtl/itpt_checker.sv =====
// ============================================================================
// itpt_checker: port-level checks for the integer to padded text formatter
// Watches the handshakes and the character run at the top-level ports.
// ============================================================================
module itpt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [itpt_pkg::CHAR_W-1:0]  character,
    input logic                         last,
    input logic                         bad_base
);

    // A stalled item keeps its character and marks.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character) &&
        $stable(last) && $stable(bad_base))
        else $error("output item changed while stalled");

    // A bad base gives one result only, a NUL that closes the run.
    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_base |-> last && (character == itpt_pkg::CH_NUL))
        else $error("bad base result is not a lone closing item");

    // Every character of a proper field is printable.
    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_base |-> character >= itpt_pkg::CH_SPACE)
        else $error("non-printable character in field");

    // After an accepted item the input is closed in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready straight after acceptance");

    // No new item is taken while a run is still open.
    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input ready in the middle of a run");

endmodule

bind integer_to_padded_text itpt_checker u_itpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last),
    .bad_base  (bad_base)
);
